/* hdl/multi_peer_serial_link_queue_core_assert.svh */
`ifndef MULTI_PEER_SERIAL_LINK_QUEUE_CORE_ASSERT_SVH
`define MULTI_PEER_SERIAL_LINK_QUEUE_CORE_ASSERT_SVH
// implication check under active-low reset
`define MPSL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication check
`define MPSL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hdl/mpsl_pkg.sv */
package mpsl_pkg;
    localparam int RING_DEPTH = 16;
    localparam int MAX_PEERS  = 4;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int SLOT_W     = $clog2(MAX_PEERS);
    localparam int MEM_AW     = PTR_W + SLOT_W;

    localparam logic [3:0] F_SELECT    = 4'd0;
    localparam logic [3:0] F_BEGIN     = 4'd1;
    localparam logic [3:0] F_BEGIN_TO  = 4'd2;
    localparam logic [3:0] F_DONE      = 4'd3;
    localparam logic [3:0] F_READ      = 4'd4;
    localparam logic [3:0] F_READ_FROM = 4'd5;
    localparam logic [3:0] F_READ_ANY  = 4'd6;
    localparam logic [3:0] F_CANCEL    = 4'd7;
    localparam logic [3:0] F_CLEAR     = 4'd8;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_HOST = 2'd1;
    localparam logic [1:0] MODE_PEER = 2'd2;
    localparam logic [2:0] NO_SLOT   = 3'd7;

    localparam logic [7:0] CTL_START    = 8'h80;
    localparam logic [7:0] CTL_FAST     = 8'h02;
    localparam logic [7:0] CTL_INTERNAL = 8'h01;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_BUSY     = 2'd2;
    localparam logic [1:0] ERR_PROTOCOL = 2'd3;
    localparam logic [1:0] RES_NONE     = 2'd0;
    localparam logic [1:0] RES_BUSY     = 2'd1;
    localparam logic [1:0] RES_PROTOCOL = 2'd2;

    localparam logic [2:0] REG_MASTER = 3'd0;
    localparam logic [2:0] REG_FAST   = 3'd1;
    localparam logic [2:0] REG_MODE   = 3'd2;
    localparam logic [2:0] REG_LOCAL  = 3'd3;
    localparam logic [2:0] REG_COUNT  = 3'd4;

    typedef struct packed {
        logic       start;
        logic       exec;
        logic       capture;
    } t_cmd;

    typedef struct packed {
        logic       out_busy;
    } t_status;

    function automatic logic [PTR_W-1:0] next_idx(input logic [PTR_W-1:0] i);
        logic [PTR_W:0] n;
        n = {1'b0, i} + 1'b1;
        next_idx = (n >= (PTR_W+1)'(RING_DEPTH)) ? '0 : n[PTR_W-1:0];
    endfunction
endpackage

/* hdl/mpsl_ctrl.sv */
module mpsl_ctrl import mpsl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_status     i_status,
    output t_cmd        o_cmd,
    output logic        o_in_ready
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid && !i_status.out_busy) begin
                    o_cmd.start = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = S_READ;
            end
            S_READ: begin
                o_cmd.capture = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE) && !i_status.out_busy;
endmodule

/* hdl/mpsl_datapath.sv */
module mpsl_datapath import mpsl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic [3:0]  i_func,
    input  logic [2:0]  i_peer,
    input  logic [7:0]  i_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [2:0]  i_cfg_val,
    output logic [31:0] o_cfg_rd,
    input  logic [2:0]  i_cfg_ridx,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [35:0] o_out
);
    logic r_master, r_fast;
    logic [1:0] r_mode, r_local;
    logic [2:0] r_count;
    logic [7:0] r_shared [RING_DEPTH];
    logic [7:0] r_prings [MAX_PEERS*RING_DEPTH];
    logic [PTR_W-1:0] r_sh, r_st;
    logic [PTR_W-1:0] r_ph [MAX_PEERS];
    logic [PTR_W-1:0] r_pt [MAX_PEERS];
    logic r_busy, r_ready;
    logic [1:0] r_err;
    logic [2:0] r_chosen, r_rxp, r_txp;
    logic [3:0] r_func;
    logic [2:0] r_peer;
    logic [7:0] r_data;
    logic [7:0] r_sh_rd, r_pr_rd;
    logic r_pop_sh, r_pop_pr;
    logic [2:0] r_pop_slot;
    logic [1:0] r_rc;
    logic r_cw;
    logic [7:0] r_cv;
    logic r_ovalid;
    logic [35:0] r_out;

    logic [1:0] emode;
    logic [1:0] rc;
    logic [1:0] err_set;
    logic       hit;
    logic [2:0] hit_slot;
    logic [2:0] xp;
    logic [SLOT_W-1:0] xs;
    logic       done_go;
    logic       sh_full;
    logic       pr_ok;
    logic       pr_full;
    logic       slot_write;
    logic [1:0] slot_mode, slot_local;
    logic [2:0] slot_count;
    logic [1:0] slot_emode;

    function automatic logic rok(input logic [1:0] m, input logic [2:0] s,
                                 input logic [2:0] c, input logic [1:0] l);
        rok = (m != MODE_NONE) && (s < c) && (s < 3'(MAX_PEERS)) && (s != {1'b0, l});
    endfunction

    function automatic logic [1:0] eff_mode(input logic [1:0] md, input logic [1:0] l,
                                            input logic [2:0] c);
        eff_mode = MODE_NONE;
        if (c >= 3'd2 && c <= 3'(MAX_PEERS)) begin
            if (md == MODE_HOST && l == 2'd0) eff_mode = MODE_HOST;
            if (md == MODE_PEER && l != 2'd0 && {1'b0, l} < c) eff_mode = MODE_PEER;
        end
    endfunction

    always_comb begin
        emode = eff_mode(r_mode, r_local, r_count);
        xp = (emode == MODE_HOST) ? r_chosen : (emode == MODE_PEER) ? 3'd0 : NO_SLOT;
        xs = xp[SLOT_W-1:0];
    end

    always_comb begin
        slot_write = i_cfg_we && (i_cfg_idx == REG_MODE || i_cfg_idx == REG_LOCAL ||
                                  i_cfg_idx == REG_COUNT);
        slot_mode  = (i_cfg_idx == REG_MODE)  ? i_cfg_val[1:0] : r_mode;
        slot_local = (i_cfg_idx == REG_LOCAL) ? i_cfg_val[1:0] : r_local;
        slot_count = (i_cfg_idx == REG_COUNT) ? i_cfg_val : r_count;
        slot_emode = eff_mode(slot_mode, slot_local, slot_count);
    end

    // select check, reused by begin_to
    always_comb begin
        rc = RES_NONE;
        err_set = ERR_NONE;
        if (emode == MODE_NONE) begin
            rc = RES_PROTOCOL; err_set = ERR_PROTOCOL;
        end else if (r_busy) begin
            rc = RES_BUSY; err_set = ERR_BUSY;
        end else if (emode == MODE_HOST) begin
            if (!rok(emode, r_peer, r_count, r_local)) begin
                rc = RES_PROTOCOL; err_set = ERR_PROTOCOL;
            end
        end else if (r_peer != 3'd0) begin
            rc = RES_PROTOCOL; err_set = ERR_PROTOCOL;
        end
    end

    always_comb begin
        hit = 1'b0;
        hit_slot = NO_SLOT;
        if (r_func == F_READ_FROM) begin
            hit = rok(emode, r_peer, r_count, r_local) &&
                  (r_ph[r_peer[SLOT_W-1:0]] != r_pt[r_peer[SLOT_W-1:0]]);
            hit_slot = r_peer;
        end else if (r_func == F_READ_ANY && emode != MODE_NONE) begin
            for (int s = MAX_PEERS-1; s >= 0; s--) begin
                if (rok(emode, 3'(s), r_count, r_local) && r_ph[s] != r_pt[s]) begin
                    hit = 1'b1;
                    hit_slot = 3'(s);
                end
            end
        end
    end

    always_comb begin
        done_go = i_cmd.exec && (r_func == F_DONE) && r_busy;
        sh_full = (next_idx(r_sh) == r_st);
        pr_ok   = rok(emode, xp, r_count, r_local);
        pr_full = (next_idx(r_ph[xs]) == r_pt[xs]);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_func <= i_func; r_peer <= i_peer; r_data <= i_data;
        end
        if (done_go && !sh_full) r_shared[r_sh] <= r_data;
        if (done_go && pr_ok && !pr_full) r_prings[{xs, r_ph[xs]}] <= r_data;
        r_sh_rd <= r_shared[r_st];
        r_pr_rd <= r_prings[{hit_slot[SLOT_W-1:0], r_pt[hit_slot[SLOT_W-1:0]]}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master <= 1'b0; r_fast <= 1'b0; r_mode <= 2'd0; r_local <= 2'd0;
            r_count <= 3'd0; r_sh <= '0; r_st <= '0; r_busy <= 1'b0; r_ready <= 1'b0;
            r_err <= ERR_NONE; r_chosen <= NO_SLOT; r_rxp <= NO_SLOT; r_txp <= NO_SLOT;
            r_ovalid <= 1'b0; r_pop_sh <= 1'b0; r_pop_pr <= 1'b0;
            for (int s = 0; s < MAX_PEERS; s++) begin
                r_ph[s] <= '0; r_pt[s] <= '0;
            end
        end else begin
            if (o_out_valid && i_out_ready) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MASTER: r_master <= i_cfg_val[0];
                    REG_FAST:   r_fast <= i_cfg_val[0];
                    REG_MODE:   r_mode <= i_cfg_val[1:0];
                    REG_LOCAL:  r_local <= i_cfg_val[1:0];
                    REG_COUNT:  r_count <= i_cfg_val;
                    default: ;
                endcase
            end
            if (slot_write) begin
                r_rxp <= NO_SLOT; r_txp <= NO_SLOT;
                r_chosen <= (slot_emode == MODE_HOST) ? 3'd1 :
                            (slot_emode == MODE_PEER) ? 3'd0 : NO_SLOT;
            end
            r_pop_sh <= i_cmd.exec && (r_func == F_READ) && (r_sh != r_st);
            r_pop_pr <= i_cmd.exec && hit;
            if (i_cmd.capture) begin
                if (r_pop_sh) begin
                    r_out[2] <= 1'b1; r_out[10:3] <= r_sh_rd; r_out[13:11] <= NO_SLOT;
                end else if (r_pop_pr) begin
                    r_out[2] <= 1'b1; r_out[10:3] <= r_pr_rd; r_out[13:11] <= r_pop_slot;
                end else begin
                    r_out[2] <= 1'b0; r_out[10:3] <= 8'd0; r_out[13:11] <= NO_SLOT;
                end
                r_out[1:0] <= r_rc; r_out[14] <= r_cw; r_out[22:15] <= r_cv;
                r_out[23] <= r_busy; r_out[24] <= r_ready; r_out[26:25] <= r_err;
                r_out[29:27] <= r_chosen; r_out[32:30] <= r_rxp; r_out[35:33] <= r_txp;
                r_ovalid <= 1'b1;
            end
            if (i_cmd.start) begin
                r_rc <= RES_NONE; r_cw <= 1'b0; r_cv <= 8'd0;
            end
            if (i_cmd.exec) begin
                case (r_func)
                    F_SELECT: begin
                        r_rc <= rc;
                        if (err_set != ERR_NONE) r_err <= err_set;
                        else r_chosen <= (emode == MODE_HOST) ? r_peer : 3'd0;
                    end
                    F_BEGIN, F_BEGIN_TO: begin
                        if (r_func == F_BEGIN_TO && rc != RES_NONE) begin
                            r_rc <= rc; r_err <= err_set;
                        end else if (r_busy) begin
                            r_rc <= RES_BUSY; r_err <= ERR_BUSY;
                        end else begin
                            if (r_func == F_BEGIN_TO)
                                r_chosen <= (emode == MODE_HOST) ? r_peer : 3'd0;
                            r_txp <= (r_func == F_BEGIN_TO) ?
                                     ((emode == MODE_HOST) ? r_peer : 3'd0) : xp;
                            r_busy <= 1'b1; r_cw <= 1'b1;
                            r_cv <= CTL_START | (r_master ? CTL_INTERNAL : 8'd0) |
                                    ((r_master && r_fast) ? CTL_FAST : 8'd0);
                        end
                    end
                    F_DONE: begin
                        if (r_busy) begin
                            r_busy <= 1'b0; r_rxp <= xp;
                            if (sh_full || (pr_ok && pr_full)) r_err <= ERR_OVERFLOW;
                            if (!sh_full) begin
                                r_sh <= next_idx(r_sh); r_ready <= 1'b1;
                            end
                            if (pr_ok && !pr_full) r_ph[xs] <= next_idx(r_ph[xs]);
                        end
                    end
                    F_READ: begin
                        if (r_sh == r_st) r_ready <= 1'b0;
                        else begin
                            r_st <= next_idx(r_st);
                            r_ready <= (r_sh != next_idx(r_st));
                        end
                    end
                    F_READ_FROM, F_READ_ANY: begin
                        if (hit) begin
                            r_pop_slot <= hit_slot;
                            r_pt[hit_slot[SLOT_W-1:0]] <= next_idx(r_pt[hit_slot[SLOT_W-1:0]]);
                        end
                    end
                    F_CANCEL: begin
                        r_busy <= 1'b0; r_cw <= 1'b1; r_cv <= 8'd0;
                    end
                    F_CLEAR: r_err <= ERR_NONE;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (i_cfg_ridx)
            REG_MASTER: o_cfg_rd = {31'd0, r_master};
            REG_FAST:   o_cfg_rd = {31'd0, r_fast};
            REG_MODE:   o_cfg_rd = {30'd0, r_mode};
            REG_LOCAL:  o_cfg_rd = {30'd0, r_local};
            REG_COUNT:  o_cfg_rd = {29'd0, r_count};
            default:    o_cfg_rd = 32'd0;
        endcase
    end

    assign o_status.out_busy = r_ovalid;
    assign o_out_valid = r_ovalid;
    assign o_out = r_out;
endmodule

/* hdl/multi_peer_serial_link_queue_core.sv */
// channel | dir | fields (tdata low to high)
// s_axis  | in  | func[3:0], peer[6:4], data_byte[14:7]
// m_axis  | out | result_code, byte_valid, byte_value, byte_peer, control_write,
//         |     | control_value, busy_res, rx_ready, last_error, selected_peer,
//         |     | last_rx_peer, last_tx_peer
// apb     | in  | registers at 4*i
// A result becomes valid once its transaction has passed the execute and ring-read states;
// the ring read port is registered, so the popped byte is registered before output.
// The next input is taken the cycle after the result is taken, so transactions never overlap.
// Reset is synchronous, active low; rings are not cleared.
// A stalled output holds and blocks the input until it is taken.
module multi_peer_serial_link_queue_core import mpsl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // func, peer, data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // result fields, lowest first
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_cmd    cmd;
    t_status st;
    logic [35:0] out_w;

    assign pready = 1'b1;

    mpsl_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid),
        .i_status(st), .o_cmd(cmd), .o_in_ready(s_axis_tready)
    );

    mpsl_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .o_status(st),
        .i_func(s_axis_tdata[3:0]), .i_peer(s_axis_tdata[6:4]),
        .i_data(s_axis_tdata[14:7]),
        .i_cfg_we(psel && penable && pwrite && pready), .i_cfg_idx(paddr[4:2]),
        .i_cfg_val(pwdata[2:0]), .o_cfg_rd(prdata), .i_cfg_ridx(paddr[4:2]),
        .i_out_ready(m_axis_tready), .o_out_valid(m_axis_tvalid),
        .o_out(out_w)
    );

    assign m_axis_tdata = {4'd0, out_w};
endmodule

/* hdl/mpsl_checker.sv */
module mpsl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
`include "multi_peer_serial_link_queue_core_assert.svh"
    `MPSL_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `MPSL_ASSERT_IMP(a_nobv, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[2], m_axis_tdata[10:3] == 8'd0)
    `MPSL_ASSERT_IMP(a_rc, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3)
    `MPSL_ASSERT_NXT(a_seq, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

bind multi_peer_serial_link_queue_core mpsl_checker u_chk (.*);
